// ===== src/wii_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wii_pkg;

  // Sizing of the index
  localparam int NUM_WORDS  = 1024;
  localparam int LIST_CAP   = 32;
  localparam int KF_ID_BITS = 16;

  // Fixed field widths
  localparam int MODE_W    = 2;
  localparam int WORD_ID_W = 20;
  localparam int KF_W      = 16;
  localparam int STATUS_W  = 3;
  localparam int ENTRY_W   = 16;
  localparam int COUNT_W   = 6;
  localparam int VOCAB_W   = 11;
  localparam int RANGE_W   = WORD_ID_W + 1;

  localparam logic [VOCAB_W-1:0] VOCAB_RESET = VOCAB_W'(1024);

  // Derived widths
  localparam int KF_STORE_W = (KF_ID_BITS < KF_W) ? KF_ID_BITS : KF_W;
  localparam int WORD_AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SLOT_W     = (LIST_CAP > 1) ? $clog2(LIST_CAP) : 1;
  localparam int LIST_DEPTH = NUM_WORDS * LIST_CAP;
  localparam int LIST_AW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_CAP + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_ERASE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_RANGE     = 3'd1,
    STS_FULL      = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COUNT,
    ST_SCAN,
    ST_SWAP,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    status_t            status;
    logic [ENTRY_W-1:0] entry;
    logic [COUNT_W-1:0] count;
    logic               last;
  } result_t;

  typedef struct packed {
    logic                  we;
    logic [LIST_AW-1:0]    waddr;
    logic [KF_STORE_W-1:0] wdata;
    logic                  re;
    logic [LIST_AW-1:0]    raddr;
  } list_req_t;

  typedef struct packed {
    logic               we;
    logic [WORD_AW-1:0] waddr;
    logic [CNT_W-1:0]   wdata;
    logic               re;
    logic [WORD_AW-1:0] raddr;
  } cnt_req_t;

endpackage

`default_nettype wire

// ===== src/wii_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wii_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/wii_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wii_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [wii_pkg::VOCAB_W-1:0]  vocab,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  wii_pkg::mode_t               in_mode,
  input  logic [wii_pkg::WORD_ID_W-1:0] in_word,
  input  logic [wii_pkg::KF_W-1:0]     in_kf,
  input  logic                         out_free,
  output logic                         res_load,
  output wii_pkg::result_t             res,
  output wii_pkg::list_req_t           list_req,
  input  logic [wii_pkg::KF_STORE_W-1:0] list_rdata,
  output wii_pkg::cnt_req_t            cnt_req,
  input  logic [wii_pkg::CNT_W-1:0]    cnt_rdata
);
  import wii_pkg::*;

  state_t                state, state_next;
  mode_t                 mode_q, mode_q_next;
  logic [KF_STORE_W-1:0] kf_q, kf_q_next;
  logic [WORD_AW-1:0]    word_q, word_q_next;
  logic [LIST_AW-1:0]    base_q, base_q_next;
  logic [CNT_W-1:0]      n_q, n_q_next;
  logic [SLOT_W-1:0]     k_q, k_q_next;
  logic [WORD_AW-1:0]    clr_q, clr_q_next;
  result_t               res_q, res_q_next;

  logic                  in_range;
  logic [WORD_AW-1:0]    in_idx;
  logic [SLOT_W-1:0]     kp1;
  logic [CNT_W-1:0]      n_m1;
  logic                  last_k;
  logic                  match;

  assign in_idx   = in_word[WORD_AW-1:0];
  assign in_range = (RANGE_W'(in_word) < RANGE_W'(vocab)) &&
                    (RANGE_W'(in_word) < RANGE_W'(NUM_WORDS));
  assign kp1      = k_q + SLOT_W'(1);
  assign n_m1     = n_q - CNT_W'(1);
  assign last_k   = (CNT_W'(k_q) == n_m1);
  assign match    = (list_rdata == kf_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_q <= '0;
    end else begin
      state <= state_next;
      clr_q <= clr_q_next;
    end
  end

  always_ff @(posedge clk) begin
    mode_q <= mode_q_next;
    kf_q   <= kf_q_next;
    word_q <= word_q_next;
    base_q <= base_q_next;
    n_q    <= n_q_next;
    k_q    <= k_q_next;
    res_q  <= res_q_next;
  end

  always_comb begin
    state_next  = state;
    mode_q_next = mode_q;
    kf_q_next   = kf_q;
    word_q_next = word_q;
    base_q_next = base_q;
    n_q_next    = n_q;
    k_q_next    = k_q;
    clr_q_next  = clr_q;
    res_q_next  = res_q;
    in_ready    = 1'b0;
    res_load    = 1'b0;
    res         = res_q;
    list_req    = '0;
    cnt_req     = '0;

    unique case (state)
      ST_CLEAR: begin
        cnt_req.we    = 1'b1;
        cnt_req.waddr = clr_q;
        cnt_req.wdata = '0;
        clr_q_next    = clr_q + WORD_AW'(1);
        if (clr_q == WORD_AW'(NUM_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_q_next = in_mode;
          kf_q_next   = in_kf[KF_STORE_W-1:0];
          word_q_next = in_idx;
          base_q_next = LIST_AW'(in_idx) * LIST_AW'(LIST_CAP);
          k_q_next    = '0;
          if (!in_range) begin
            res_q_next = '{status: STS_RANGE, entry: '0, count: '0, last: 1'b1};
            state_next = ST_EMIT;
          end else begin
            cnt_req.re    = 1'b1;
            cnt_req.raddr = in_idx;
            state_next    = ST_COUNT;
          end
        end
      end

      ST_COUNT: begin
        n_q_next = cnt_rdata;
        unique case (mode_q)
          MODE_ADD: begin
            if (cnt_rdata == CNT_W'(LIST_CAP)) begin
              res_q_next = '{status: STS_FULL, entry: '0,
                             count: COUNT_W'(cnt_rdata), last: 1'b1};
            end else begin
              list_req.we    = 1'b1;
              list_req.waddr = base_q + LIST_AW'(cnt_rdata);
              list_req.wdata = kf_q;
              cnt_req.we     = 1'b1;
              cnt_req.waddr  = word_q;
              cnt_req.wdata  = cnt_rdata + CNT_W'(1);
              res_q_next = '{status: STS_OK, entry: '0,
                             count: COUNT_W'(cnt_rdata + CNT_W'(1)), last: 1'b1};
            end
            state_next = ST_EMIT;
          end
          MODE_ERASE: begin
            if (cnt_rdata == '0) begin
              res_q_next = '{status: STS_NOT_FOUND, entry: '0, count: '0, last: 1'b1};
              state_next = ST_EMIT;
            end else begin
              list_req.re    = 1'b1;
              list_req.raddr = base_q;
              state_next     = ST_SCAN;
            end
          end
          MODE_READ: begin
            if (cnt_rdata == '0) begin
              res_q_next = '{status: STS_EMPTY, entry: '0, count: '0, last: 1'b1};
              state_next = ST_EMIT;
            end else begin
              list_req.re    = 1'b1;
              list_req.raddr = base_q;
              state_next     = ST_READ;
            end
          end
          default: begin
            res_q_next = '{status: STS_OK, entry: '0,
                           count: COUNT_W'(cnt_rdata), last: 1'b1};
            state_next = ST_EMIT;
          end
        endcase
      end

      ST_SCAN: begin
        // Compare slot k; on a hit fetch the tail entry for the swap
        priority if (match) begin
          list_req.re    = 1'b1;
          list_req.raddr = base_q + LIST_AW'(n_m1);
          state_next     = ST_SWAP;
        end else if (last_k) begin
          res_q_next = '{status: STS_NOT_FOUND, entry: '0,
                         count: COUNT_W'(n_q), last: 1'b1};
          state_next = ST_EMIT;
        end else begin
          list_req.re    = 1'b1;
          list_req.raddr = base_q + LIST_AW'(kp1);
          k_q_next       = kp1;
        end
      end

      ST_SWAP: begin
        list_req.we    = 1'b1;
        list_req.waddr = base_q + LIST_AW'(k_q);
        list_req.wdata = list_rdata;
        cnt_req.we     = 1'b1;
        cnt_req.waddr  = word_q;
        cnt_req.wdata  = n_m1;
        res_q_next = '{status: STS_OK, entry: '0, count: COUNT_W'(n_m1), last: 1'b1};
        state_next = ST_EMIT;
      end

      ST_READ: begin
        if (out_free) begin
          res_load = 1'b1;
          res = '{status: STS_OK, entry: ENTRY_W'(list_rdata),
                  count: COUNT_W'(n_q), last: last_k};
          if (last_k) begin
            state_next = ST_IDLE;
          end else begin
            list_req.re    = 1'b1;
            list_req.raddr = base_q + LIST_AW'(kp1);
            k_q_next       = kp1;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("result loaded into a full output register");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (cnt_req.we && state != ST_CLEAR) |-> (cnt_req.wdata <= CNT_W'(LIST_CAP)))
    else $error("list count written above capacity");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_READ) |-> (CNT_W'(k_q) < n_q))
    else $error("slot index walked past the list end");
`endif

endmodule

`default_nettype wire

// ===== src/word_inverted_index.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Signals                            Contents
// s_axis    in   tvalid tready tdata[39:0] tuser    one (word, keyframe) pair and mode
// m_axis    out  tvalid tready tdata[23:0] tuser    one result word, tlast on the final one
// cfg       in   cfg_wen cfg_wdata[10:0]            vocab_words register
//
// Pace: erase walks the list with one list slot compared per cycle. The single
//   read port of the list memory sets the pace of erase and read.
// Reset: the count memory is swept to zero, one word per cycle, over all
//   NUM_WORDS words (1024) after rst falls; s_axis_tready stays low meanwhile.
// Stalls: one output register holds a finished result; a new pair is taken
//   while it waits, and the walk of a read list pauses while m_axis_tready is low.

module word_inverted_index (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wen,
  input  logic [10:0] cfg_wdata,      // vocab_words
  // input pairs
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [19:0] word_id, [35:20] keyframe_id, [39:36] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] entry_id, [21:16] entry_count, [23:22] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  output logic        m_axis_tlast    // last
);
  import wii_pkg::*;

  logic [VOCAB_W-1:0]    vocab;
  logic                  out_free;
  logic                  res_load;
  result_t               res;
  result_t               out_q;
  list_req_t             list_req;
  cnt_req_t              cnt_req;
  logic [KF_STORE_W-1:0] list_rdata;
  logic [CNT_W-1:0]      cnt_rdata;

  // Hold the word-range register; the user must write it only while the block is idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      vocab <= VOCAB_RESET;
    end else if (cfg_wen) begin
      vocab <= cfg_wdata;
    end
  end

  // Keyframe lists: LIST_CAP slots per word, contents valid only below the count
  wii_ram #(
    .WIDTH (KF_STORE_W),
    .DEPTH (LIST_DEPTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (list_req.we),
    .waddr (list_req.waddr),
    .wdata (list_req.wdata),
    .re    (list_req.re),
    .raddr (list_req.raddr),
    .rdata (list_rdata)
  );

  // Per-word entry counts, cleared by the sweep after reset
  wii_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_WORDS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_req.we),
    .waddr (cnt_req.waddr),
    .wdata (cnt_req.wdata),
    .re    (cnt_req.re),
    .raddr (cnt_req.raddr),
    .rdata (cnt_rdata)
  );

  // Sequencer: one pair at a time, so a write always lands before the next
  // read of the same entry and no forwarding is needed
  wii_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .vocab      (vocab),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_mode    (mode_t'(s_axis_tuser)),
    .in_word    (s_axis_tdata[WORD_ID_W-1:0]),
    .in_kf      (s_axis_tdata[WORD_ID_W +: KF_W]),
    .out_free   (out_free),
    .res_load   (res_load),
    .res        (res),
    .list_req   (list_req),
    .list_rdata (list_rdata),
    .cnt_req    (cnt_req),
    .cnt_rdata  (cnt_rdata)
  );

  // Output register: free when empty or being drained this cycle
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign m_axis_tdata = {2'b00, out_q.count, out_q.entry};
  assign m_axis_tuser = out_q.status;
  assign m_axis_tlast = out_q.last;

`ifndef NO_ASSERTIONS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second pair taken while one is in progress");

  a_clear_block: assert property (@(posedge clk)
    $past(rst) |-> !s_axis_tready)
    else $error("pair taken before the count sweep");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("pending result dropped");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_word_inverted_index.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the keyframe inverted index.
//
// Every pair taken on s_axis is run through a local copy of the index (per-word
// keyframe lists plus counts, and the vocab_words register). That copy queues
// the result words that the pair should cause. One process owns m_axis_tready.
// It pops and compares each result word that is taken. The stimulus runs as
// named test tasks: directed corner cases, a full list, vocabulary limits,
// random traffic over a few hot words, and a long receiver hold-off.
module tb_word_inverted_index;
  import wii_pkg::*;

  localparam int          HOT_WORDS    = 8;      // words that random traffic keeps busy
  localparam int          HOLD_CYCLES  = 300;    // long receiver hold-off
  localparam int          QUIET_LIMIT  = 8000;   // cycles with no handshake before giving up
  localparam int          SETTLE       = 8;      // idle cycles before a register write
  localparam int          TAIL_CYCLES  = 64;     // watch for stray result words at the end
  localparam logic [15:0] STALL_PATTERN = 16'b1011_0011_1110_0101;
  localparam logic [15:0] KF_MASK =
    (KF_ID_BITS >= 16) ? 16'hFFFF : 16'((1 << KF_ID_BITS) - 1);

  // DUT ports; every input starts at a known value
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;    // [19:0] word_id, [35:20] keyframe_id, [39:36] zero
  logic [1:0]  s_axis_tuser = '0;    // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [15:0] entry_id, [21:16] entry_count, [23:22] zero
  logic [2:0]  m_axis_tuser;         // [2:0] status
  logic        m_axis_tlast;

  // Local copy of the index
  logic [15:0]  kf_lists [NUM_WORDS * LIST_CAP];
  logic [6:0]   list_len [NUM_WORDS];
  logic [10:0]  vocab_reg;
  result_t      result_words_due [$];

  int          fail_count    = 0;
  int unsigned burst_left    = 0;
  bit          sender_steady = 1'b0;
  int unsigned hold_requests = 0;    // bumped by the tests, served by the receiver
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned recv_cycle    = 0;
  int unsigned quiet_cycles  = 0;

  word_inverted_index i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Index copy: apply one pair and queue the result words it causes
  // ---------------------------------------------------------------------------
  task automatic queue_result(input status_t st, input logic [15:0] entry,
                              input int unsigned n, input bit fin);
    result_t r;
    r.status = st;
    r.entry  = entry;
    r.count  = COUNT_W'(n);
    r.last   = fin;
    result_words_due.push_back(r);
  endtask

  task automatic index_apply(input mode_t op, input logic [19:0] wid,
                             input logic [15:0] kf_raw);
    logic [15:0] kf;
    int unsigned lim, base, n, k, hit;
    kf  = kf_raw & KF_MASK;
    lim = (vocab_reg < NUM_WORDS) ? vocab_reg : NUM_WORDS;
    // Out-of-range words touch nothing, whatever the mode
    if (wid >= lim) begin
      queue_result(STS_RANGE, '0, 0, 1'b1);
      return;
    end
    base = wid * LIST_CAP;
    n    = list_len[wid];
    case (op)
      MODE_ADD: begin
        if (n >= LIST_CAP) begin
          queue_result(STS_FULL, '0, n, 1'b1);
        end else begin
          kf_lists[base + n] = kf;
          list_len[wid] = 7'(n + 1);
          queue_result(STS_OK, '0, n + 1, 1'b1);
        end
      end
      MODE_ERASE: begin
        // first match from the front takes the last entry
        hit = n;
        for (k = 0; k < n; k++) begin
          if (kf_lists[base + k] == kf) begin
            hit = k;
            break;
          end
        end
        if (hit == n) begin
          queue_result(STS_NOT_FOUND, '0, n, 1'b1);
        end else begin
          kf_lists[base + hit] = kf_lists[base + n - 1];
          list_len[wid] = 7'(n - 1);
          queue_result(STS_OK, '0, n - 1, 1'b1);
        end
      end
      MODE_READ: begin
        if (n == 0) begin
          queue_result(STS_EMPTY, '0, 0, 1'b1);
        end else begin
          for (k = 0; k < n; k++) queue_result(STS_OK, kf_lists[base + k], n, k + 1 == n);
        end
      end
      default: begin
        queue_result(STS_OK, '0, n, 1'b1);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offer one pair, update the index copy on acceptance, then maybe gap
  // ---------------------------------------------------------------------------
  task automatic send_pair(input mode_t op, input logic [19:0] wid, input logic [15:0] kf);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, kf, wid};
    s_axis_tuser  <= op;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    index_apply(op, wid, kf);
    // Bursts of random length; a steady sender keeps tvalid up throughout
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if (sender_steady) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(10, 40);
      else gap = $urandom_range(0, 5);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop tvalid and hold until every queued result word has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (result_words_due.size() != 0) @(posedge clk);
  endtask

  // Register writes only go in once the block has gone quiet
  task automatic write_vocab(input logic [10:0] v);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    vocab_reg = v;
  endtask

  // Random pair aimed at a few hot words so lists grow, shrink and repeat ids
  task automatic random_pair(input int unsigned hot_base);
    int unsigned pick;
    logic [19:0] wid;
    logic [15:0] kf;
    mode_t       op;
    pick = $urandom_range(0, 99);
    if (pick < 5) wid = 20'($urandom);
    else if (pick < 10) wid = 20'($urandom_range(0, NUM_WORDS - 1));
    else wid = 20'(hot_base + $urandom_range(0, HOT_WORDS - 1));
    pick = $urandom_range(0, 99);
    op = (pick < 42) ? MODE_ADD : (pick < 70) ? MODE_ERASE :
         (pick < 94) ? MODE_READ : MODE_NOP;
    // a small id pool makes duplicates likely
    kf = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 7));
    // most erases name an id that is really in the list
    if (op == MODE_ERASE && wid < NUM_WORDS && list_len[wid] > 0 &&
        $urandom_range(0, 3) != 0)
      kf = kf_lists[wid * LIST_CAP + $urandom_range(0, list_len[wid] - 1)];
    send_pair(op, wid, kf);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    sender_steady = 1'b0;
    send_pair(MODE_READ,  20'd0, 16'h0000);       // empty list
    send_pair(MODE_ERASE, 20'd0, 16'h0000);       // erase on an empty list
    send_pair(MODE_ADD,   20'd0, 16'h0000);
    send_pair(MODE_ADD,   20'd0, 16'hFFFF);
    send_pair(MODE_ADD,   20'd0, 16'hFFFF);       // duplicate is kept
    send_pair(MODE_ADD,   20'd0, 16'hA5C3);
    send_pair(MODE_READ,  20'd0, 16'hFFFF);
    send_pair(MODE_ERASE, 20'd0, 16'hFFFF);       // first match takes the tail
    send_pair(MODE_ERASE, 20'd0, 16'h7777);       // no match
    send_pair(MODE_NOP,   20'd0, 16'h1234);
    send_pair(MODE_READ,  20'd0, 16'h0000);
    send_pair(MODE_ADD,   20'd1023, 16'h5A5A);    // top valid word
    send_pair(MODE_READ,  20'd1023, 16'h0000);
    send_pair(MODE_ERASE, 20'd1023, 16'h5A5A);    // erase the only entry
    send_pair(MODE_READ,  20'd1023, 16'h0000);
    send_pair(MODE_ADD,   20'd1024, 16'h0001);    // first word out of range
    send_pair(MODE_READ,  20'hFFFFF, 16'hFFFF);
    send_pair(MODE_ERASE, 20'd1024, 16'h0000);
    send_pair(MODE_NOP,   20'hFFFFF, 16'h0000);
    send_pair(MODE_ERASE, 20'd0, 16'h0000);       // match in the first slot
    send_pair(MODE_READ,  20'd0, 16'h0000);
  endtask

  task automatic test_full_list();
    logic [19:0] wid;
    int unsigned k;
    wid = 20'($urandom_range(100, NUM_WORDS - 100));
    for (k = 0; k < LIST_CAP; k++) send_pair(MODE_ADD, wid, 16'($urandom));
    send_pair(MODE_ADD, wid, 16'($urandom));      // full: dropped
    send_pair(MODE_READ, wid, 16'h0000);
    send_pair(MODE_ERASE, wid, kf_lists[wid * LIST_CAP + LIST_CAP / 2]);
    send_pair(MODE_ERASE, wid, kf_lists[wid * LIST_CAP + list_len[wid] - 1]);
    send_pair(MODE_ERASE, wid, kf_lists[wid * LIST_CAP]);
    send_pair(MODE_ADD, wid, 16'hFFFF);
    send_pair(MODE_READ, wid, 16'h0000);
  endtask

  task automatic test_vocab_limits();
    logic [10:0]  setting [6];
    logic [19:0]  probe [6];
    int unsigned  lim, s, p;
    setting = '{11'd0, 11'd1, 11'd2047, 11'd517,
                11'($urandom_range(2, NUM_WORDS - 1)), VOCAB_RESET};
    for (s = 0; s < 6; s++) begin
      write_vocab(setting[s]);
      lim = (setting[s] < NUM_WORDS) ? setting[s] : NUM_WORDS;
      // probe both sides of the boundary and the ends of the word range
      probe = '{20'd0, 20'(lim - 1), 20'(lim), 20'(lim + 1), 20'd1023, 20'd1024};
      for (p = 0; p < 6; p++) begin
        send_pair(MODE_ADD, probe[p], 16'($urandom));
        send_pair(MODE_READ, probe[p], 16'($urandom));
      end
    end
  endtask

  task automatic test_random();
    int unsigned hot_base, k;
    // steady sender, full vocabulary
    sender_steady = 1'b1;
    hot_base = $urandom_range(0, NUM_WORDS - HOT_WORDS);
    for (k = 0; k < 75; k++) random_pair(hot_base);
    // pause the sender until everything is back, then go bursty
    wait_drained();
    sender_steady = 1'b0;
    hot_base = $urandom_range(0, NUM_WORDS - HOT_WORDS);
    for (k = 0; k < 75; k++) random_pair(hot_base);
    // vocabulary edge cuts through the hot words
    hot_base = $urandom_range(8, NUM_WORDS - HOT_WORDS);
    write_vocab(11'(hot_base + HOT_WORDS / 2));
    for (k = 0; k < 75; k++) random_pair(hot_base);
    write_vocab(VOCAB_RESET);
    // top of the word range
    for (k = 0; k < 75; k++) random_pair(NUM_WORDS - HOT_WORDS);
  endtask

  task automatic test_backpressure();
    int unsigned k;
    // Hold the receiver off while the sender keeps offering, so the block backs up
    wait_drained();
    hold_requests <= hold_requests + 1;
    sender_steady = 1'b1;
    for (k = 0; k < 30; k++) random_pair(NUM_WORDS - HOT_WORDS);
    sender_steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: check each taken result word, then pick the next tready
  // ---------------------------------------------------------------------------
  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t due;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (result_words_due.size() == 0) begin
        $error("result word with none due: status %0d entry %0h count %0d last %0b",
               m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[21:16], m_axis_tlast);
        fail_count++;
      end else begin
        due = result_words_due.pop_front();
        check_field("status", 16'(due.status), 16'(m_axis_tuser));
        check_field("entry_id", due.entry, m_axis_tdata[15:0]);
        check_field("entry_count", 16'(due.count), 16'(m_axis_tdata[21:16]));
        check_field("last", 16'(due.last), 16'(m_axis_tlast));
      end
    end
    recv_cycle++;
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    // Stall style rotates through four styles as recv_cycle advances; a hold-off overrides it
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case ((recv_cycle / 256) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= STALL_PATTERN[recv_cycle % 16];
        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Watchdog: give up after a long stretch with no handshake on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (list_len[i]) list_len[i] = '0;
    foreach (kf_lists[i]) kf_lists[i] = '0;
    vocab_reg = VOCAB_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // the count sweep after reset shows up as tready low; send_pair waits it out
    test_directed();
    test_full_list();
    test_vocab_limits();
    test_random();
    test_backpressure();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (result_words_due.size() != 0) begin
      $error("%0d result words never arrived", result_words_due.size());
      fail_count++;
    end
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== word_inverted_index.f =====
src/wii_pkg.sv
src/wii_ram.sv
src/wii_ctrl.sv
src/word_inverted_index.sv
tb/sv/tb_word_inverted_index.sv
